@@ hw/rtl/websocket_frame_deframer_defines.svh @@
// ----------------------------------------------------------------------------
// WebSocket deframer assertion macros
// Shared property wrappers for the checker of the deframer.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define WSD_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// Next-cycle implication, disabled during reset.
`define WSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

@@ hw/rtl/wsd_pkg.sv @@
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Types, codes and small helper functions shared by the deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package wsd_pkg;

  localparam int unsigned ADDR_W = 3;
  localparam logic [0:0] REG_MAX_IDX = 1'b0;
  localparam logic [31:0] MAX_MSG_RESET = 32'h0010_0000;

  localparam logic [3:0] OP_CONT  = 4'd0;
  localparam logic [3:0] OP_TEXT  = 4'd1;
  localparam logic [3:0] OP_BIN   = 4'd2;
  localparam logic [3:0] OP_CLOSE = 4'd8;
  localparam logic [3:0] OP_PING  = 4'd9;
  localparam logic [3:0] OP_PONG  = 4'd10;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;
  localparam logic [62:0] CTRL_MAX_LEN = 63'd125;

  localparam logic [15:0] ST_PROTOCOL = 16'd1002;
  localparam logic [15:0] ST_BAD_DATA = 16'd1007;
  localparam logic [15:0] ST_TOO_BIG  = 16'd1009;

  typedef enum logic [2:0] {
    KIND_DATA  = 3'd0,
    KIND_CTRL  = 3'd1,
    KIND_END   = 3'd2,
    KIND_PING  = 3'd3,
    KIND_PONG  = 3'd4,
    KIND_CLOSE = 3'd5,
    KIND_ERROR = 3'd6
  } kind_e;

  typedef enum logic [3:0] {
    ERR_NONE     = 4'd0,
    ERR_RSV      = 4'd1,
    ERR_OPCODE   = 4'd2,
    ERR_UNMASKED = 4'd3,
    ERR_LEN_MSB  = 4'd4,
    ERR_SIZE     = 4'd5,
    ERR_CONTROL  = 4'd6,
    ERR_CONT     = 4'd7,
    ERR_EXP_CONT = 4'd8,
    ERR_UTF8     = 4'd9,
    ERR_CLOSE    = 4'd10
  } err_e;

  typedef enum logic [4:0] {
    PH_B0   = 5'b00001,
    PH_B1   = 5'b00010,
    PH_LEN  = 5'b00100,
    PH_MASK = 5'b01000,
    PH_PAY  = 5'b10000
  } phase_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic        msg_type;
    err_e        error;
    logic [15:0] status_code;
    logic        last;
  } res_t;

  typedef struct packed {
    res_t       r0;
    res_t       r1;
    logic [1:0] n;
  } push_t;

  typedef struct packed {
    logic        ok;
    logic [1:0]  rem;
    logic [20:0] val;
    logic [1:0]  seq;
  } utf_t;

  function automatic res_t mk_fail(err_e e);
    res_t r;
    r = '0;
    r.kind = KIND_ERROR;
    r.error = e;
    r.status_code = (e == ERR_SIZE) ? ST_TOO_BIG : (e == ERR_UTF8) ? ST_BAD_DATA : ST_PROTOCOL;
    return r;
  endfunction

  function automatic res_t mk_res(kind_e k, logic [7:0] d, logic t, logic [15:0] st);
    res_t r;
    r = '0;
    r.kind = k;
    r.data = d;
    r.msg_type = t;
    r.status_code = st;
    return r;
  endfunction

  function automatic logic close_code_ok(logic [15:0] c);
    return (c >= 16'd1000 && c <= 16'd1014 && c != 16'd1004 && c != 16'd1005 &&
            c != 16'd1006) || (c >= 16'd3000 && c <= 16'd4999);
  endfunction

  // One byte of incremental UTF-8 decoding.
  function automatic utf_t utf8_step(utf_t s, logic [7:0] b);
    utf_t r;
    logic [20:0] v;
    r = s;
    r.ok = 1'b1;
    v = {s.val[14:0], b[5:0]};
    if (s.rem == 2'd0) begin
      if (!b[7]) begin
        r.ok = 1'b1;
      end else if (b[7:5] == 3'b110) begin
        r.rem = 2'd1; r.val = {16'd0, b[4:0]}; r.seq = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        r.rem = 2'd2; r.val = {17'd0, b[3:0]}; r.seq = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        r.rem = 2'd3; r.val = {18'd0, b[2:0]}; r.seq = 2'd3;
      end else begin
        r.ok = 1'b0;
      end
    end else if (b[7:6] != 2'b10) begin
      r.ok = 1'b0;
    end else begin
      r.val = v;
      r.rem = s.rem - 2'd1;
      if (r.rem == 2'd0) begin
        if ((s.seq == 2'd1 && v < 21'h80) || (s.seq == 2'd2 && v < 21'h800) ||
            (s.seq == 2'd3 && v < 21'h10000) || v > 21'h10ffff ||
            (v >= 21'hd800 && v <= 21'hdfff)) begin
          r.ok = 1'b0;
        end
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/wsd_if.sv @@
// ----------------------------------------------------------------------------
// WebSocket deframer channels
// Valid/ready channels for the input byte stream and the result stream.
// ----------------------------------------------------------------------------
`default_nettype none

interface wsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface wsd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  data;
  logic        msg_type;
  logic [3:0]  error;
  logic [15:0] status_code;
  logic        last;
  modport source (output valid, output kind, output data, output msg_type, output error,
                  output status_code, output last, input ready);
  modport sink (input valid, input kind, input data, input msg_type, input error,
                input status_code, input last, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/wsd_core.sv @@
// ----------------------------------------------------------------------------
// WebSocket deframer parser
// Per-byte header decode, unmasking, frame checks and UTF-8 validation.
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          fire_i,
  input  wire logic [7:0]    byte_i,
  input  wire logic [31:0]   max_i,
  output wsd_pkg::push_t     push_o
);
  import wsd_pkg::*;

  phase_e      phase_q, phase_d;
  logic [3:0]  hdr_q, hdr_d;
  logic        fin_q, fin_d;
  logic [3:0]  op_q, op_d;
  logic [62:0] fl_q, fl_d;
  logic [31:0] mask_q, mask_d;
  logic [62:0] pidx_q, pidx_d;
  logic        infrag_q, infrag_d;
  logic        ftype_q, ftype_d;
  logic [32:0] total_q, total_d;
  logic [1:0]  urem_q, urem_d;
  logic [20:0] uval_q, uval_d;
  logic [1:0]  useq_q, useq_d;
  logic [15:0] close_q, close_d;
  logic        stop_q, stop_d;

  logic        ld_go, fe_go;
  logic [62:0] ld_len, fl_new, pidx_nxt;
  logic [33:0] sum;
  logic [7:0]  d, mbyte;
  logic [15:0] code;
  utf_t        u;
  res_t        r0, r1, fe;
  logic        fe_vld, bad;
  logic [1:0]  n;

  always_comb begin
    phase_d = phase_q; hdr_d = hdr_q; fin_d = fin_q; op_d = op_q; fl_d = fl_q;
    mask_d = mask_q; pidx_d = pidx_q; infrag_d = infrag_q; ftype_d = ftype_q;
    total_d = total_q; urem_d = urem_q; uval_d = uval_q; useq_d = useq_q;
    close_d = close_q; stop_d = stop_q;
    ld_go = 1'b0; fe_go = 1'b0; ld_len = '0; fe = '0; fe_vld = 1'b0; bad = 1'b0;
    r0 = '0; r1 = '0; n = 2'd0;
    fl_new = {fl_q[54:0], byte_i};
    pidx_nxt = pidx_q + 63'd1;
    sum = '0;
    code = {close_q[15:8], byte_i};
    u = '0;
    unique case (pidx_q[1:0])
      2'd0: mbyte = mask_q[31:24];
      2'd1: mbyte = mask_q[23:16];
      2'd2: mbyte = mask_q[15:8];
      default: mbyte = mask_q[7:0];
    endcase
    d = byte_i ^ mbyte;

    if (!stop_q) begin
      unique case (phase_q)
        PH_B0: begin
          if (byte_i[6:4] != 3'd0) begin
            r0 = mk_fail(ERR_RSV); n = 2'd1; stop_d = 1'b1;
          end else if (!(byte_i[3:0] <= OP_BIN ||
                         (byte_i[3:0] >= OP_CLOSE && byte_i[3:0] <= OP_PONG))) begin
            r0 = mk_fail(ERR_OPCODE); n = 2'd1; stop_d = 1'b1;
          end else begin
            op_d = byte_i[3:0];
            fin_d = byte_i[7];
            phase_d = PH_B1;
          end
        end
        PH_B1: begin
          if (!byte_i[7]) begin
            r0 = mk_fail(ERR_UNMASKED); n = 2'd1; stop_d = 1'b1;
          end else begin
            mask_d = '0;
            pidx_d = '0;
            if (byte_i[6:0] == LEN_EXT16 || byte_i[6:0] == LEN_EXT64) begin
              hdr_d = (byte_i[6:0] == LEN_EXT16) ? 4'd2 : 4'd8;
              fl_d = '0;
              phase_d = PH_LEN;
            end else begin
              ld_go = 1'b1;
              ld_len = {56'd0, byte_i[6:0]};
            end
          end
        end
        PH_LEN: begin
          if (hdr_q == 4'd8 && byte_i[7]) begin
            r0 = mk_fail(ERR_LEN_MSB); n = 2'd1; stop_d = 1'b1;
          end else begin
            fl_d = fl_new;
            hdr_d = hdr_q - 4'd1;
            if (hdr_q == 4'd1) begin
              ld_go = 1'b1;
              ld_len = fl_new;
            end
          end
        end
        PH_MASK: begin
          mask_d = {mask_q[23:0], byte_i};
          hdr_d = hdr_q - 4'd1;
          if (hdr_q == 4'd1) begin
            if (fl_q == '0) fe_go = 1'b1;
            else phase_d = PH_PAY;
          end
        end
        PH_PAY: begin
          pidx_d = pidx_nxt;
          u = utf8_step('{ok: 1'b1, rem: urem_q, val: uval_q, seq: useq_q}, d);
          if (!op_q[3]) begin
            r0 = mk_res(KIND_DATA, d, ftype_q, 16'd0); n = 2'd1;
            if (!ftype_q) begin
              urem_d = u.rem; uval_d = u.val; useq_d = u.seq;
              if (!u.ok) begin
                r1 = mk_fail(ERR_UTF8); n = 2'd2; stop_d = 1'b1;
              end
            end
          end else begin
            r0 = mk_res(KIND_CTRL, d, 1'b0, 16'd0); n = 2'd1;
            if (op_q == OP_CLOSE) begin
              if (pidx_q == '0) begin
                close_d = {d, 8'd0};
              end else if (pidx_q == 63'd1) begin
                code = {close_q[15:8], d};
                close_d = code;
                bad = !close_code_ok(code);
              end else begin
                urem_d = u.rem; uval_d = u.val; useq_d = u.seq;
                bad = !u.ok;
              end
              if (bad) begin
                r1 = mk_fail(ERR_CLOSE); n = 2'd2; stop_d = 1'b1;
              end
            end
          end
          if (n == 2'd1 && pidx_nxt >= fl_q) fe_go = 1'b1;
        end
        default: phase_d = PH_B0;
      endcase

      // Frame checks once the payload length is complete.
      if (ld_go) begin
        fl_d = ld_len;
        sum = {1'b0, total_q} + {2'd0, ld_len[31:0]};
        if (ld_len > {31'd0, max_i}) begin
          r0 = mk_fail(ERR_SIZE); n = 2'd1; stop_d = 1'b1;
        end else if (op_q[3] && (!fin_q || ld_len > CTRL_MAX_LEN)) begin
          r0 = mk_fail(ERR_CONTROL); n = 2'd1; stop_d = 1'b1;
        end else if (op_q == OP_CONT && !infrag_q) begin
          r0 = mk_fail(ERR_CONT); n = 2'd1; stop_d = 1'b1;
        end else if (op_q == OP_CONT && sum > {2'd0, max_i}) begin
          r0 = mk_fail(ERR_SIZE); n = 2'd1; stop_d = 1'b1;
        end else if ((op_q == OP_TEXT || op_q == OP_BIN) && infrag_q) begin
          r0 = mk_fail(ERR_EXP_CONT); n = 2'd1; stop_d = 1'b1;
        end else begin
          if (op_q == OP_CONT) begin
            total_d = sum[32:0];
          end else if (op_q == OP_TEXT || op_q == OP_BIN) begin
            ftype_d = (op_q == OP_BIN);
            total_d = ld_len[32:0];
            urem_d = '0; uval_d = '0; useq_d = '0;
            infrag_d = !fin_q;
          end else if (op_q == OP_CLOSE) begin
            urem_d = '0; uval_d = '0; useq_d = '0;
            close_d = '0;
          end
          phase_d = PH_MASK;
          hdr_d = 4'd4;
        end
      end

      // End of frame result, using the UTF-8 state after this byte.
      if (fe_go) begin
        phase_d = PH_B0;
        fe_vld = 1'b1;
        if (op_q == OP_PING) begin
          fe = mk_res(KIND_PING, 8'd0, 1'b0, 16'd0);
        end else if (op_q == OP_PONG) begin
          fe = mk_res(KIND_PONG, 8'd0, 1'b0, 16'd0);
        end else if (op_q == OP_CLOSE) begin
          stop_d = 1'b1;
          if (fl_q == 63'd1 || urem_d != 2'd0) fe = mk_fail(ERR_CLOSE);
          else fe = mk_res(KIND_CLOSE, 8'd0, 1'b0, (fl_q >= 63'd2) ? close_d : 16'd0);
        end else if (!fin_q) begin
          fe_vld = 1'b0;
        end else if (!ftype_q && urem_d != 2'd0) begin
          stop_d = 1'b1;
          fe = mk_fail(ERR_UTF8);
        end else begin
          infrag_d = 1'b0;
          fe = mk_res(KIND_END, 8'd0, ftype_q, 16'd0);
        end
        if (fe_vld) begin
          if (n == 2'd0) begin
            r0 = fe; n = 2'd1;
          end else begin
            r1 = fe; n = 2'd2;
          end
        end
      end
    end

    if (n == 2'd1) r0.last = 1'b1;
    if (n == 2'd2) r1.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_B0; hdr_q <= '0; fin_q <= 1'b0; op_q <= '0; fl_q <= '0;
      mask_q <= '0; pidx_q <= '0; infrag_q <= 1'b0; ftype_q <= 1'b0; total_q <= '0;
      urem_q <= '0; uval_q <= '0; useq_q <= '0; close_q <= '0; stop_q <= 1'b0;
    end else if (fire_i) begin
      phase_q <= phase_d; hdr_q <= hdr_d; fin_q <= fin_d; op_q <= op_d; fl_q <= fl_d;
      mask_q <= mask_d; pidx_q <= pidx_d; infrag_q <= infrag_d; ftype_q <= ftype_d;
      total_q <= total_d; urem_q <= urem_d; uval_q <= uval_d; useq_q <= useq_d;
      close_q <= close_d; stop_q <= stop_d;
    end
  end

  assign push_o.r0 = r0;
  assign push_o.r1 = r1;
  assign push_o.n = fire_i ? n : 2'd0;

endmodule

`default_nettype wire

@@ hw/rtl/wsd_fifo.sv @@
// ----------------------------------------------------------------------------
// WebSocket deframer result queue
// Four-entry queue taking up to two results per cycle and giving one.
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire wsd_pkg::push_t  push_i,
  output logic                 room_o,
  output logic                 valid_o,
  input  wire logic            ready_i,
  output wsd_pkg::res_t        res_o
);
  import wsd_pkg::*;

  res_t       mem_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;
  logic       pop;

  assign valid_o = (cnt_q != 3'd0);
  assign pop = valid_o && ready_i;
  assign room_o = (cnt_q <= 3'd2);
  assign res_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) mem_q[wr_q] <= push_i.r0;
    if (push_i.n == 2'd2) mem_q[wr_q + 2'd1] <= push_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_q <= wr_q + push_i.n;
      if (pop) rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_q + {1'b0, push_i.n} - {2'd0, pop};
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/websocket_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// An accepted byte waits in the input register; its results are offered from the queue.
// Throughput: one byte per cycle while results drain; the parser takes a byte only
// when the four-entry result queue has room for two results, so the input stalls
// while three or more results wait.
// Reset clears all parser state; the message size limit register resets to 1048576.
// ----------------------------------------------------------------------------
`default_nettype none

module websocket_frame_deframer (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  wsd_in_if.sink                            in_chan,
  wsd_out_if.source                         out_chan,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [wsd_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import wsd_pkg::*;

  logic [31:0] max_q;
  logic        in_vld_q;
  logic [7:0]  in_byte_q;
  logic        fire, room;
  push_t       push;
  res_t        res;
  logic        reg_hit;

  assign pready = 1'b1;
  assign reg_hit = (paddr[ADDR_W-1:2] == REG_MAX_IDX);
  assign prdata = reg_hit ? max_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MAX_MSG_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      max_q <= pwdata;
    end
  end

  // The input register is processed once the queue can take two results.
  assign fire = in_vld_q && room;
  assign in_chan.ready = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_chan.ready) begin
      in_vld_q <= in_chan.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_chan.ready && in_chan.valid) in_byte_q <= in_chan.in_byte;
  end

  wsd_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (in_byte_q),
    .max_i  (max_q),
    .push_o (push)
  );

  wsd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (out_chan.valid),
    .ready_i (out_chan.ready),
    .res_o   (res)
  );

  assign out_chan.kind = res.kind;
  assign out_chan.data = res.data;
  assign out_chan.msg_type = res.msg_type;
  assign out_chan.error = res.error;
  assign out_chan.status_code = res.status_code;
  assign out_chan.last = res.last;

endmodule

`default_nettype wire

@@ hw/rtl/wsd_checker.sv @@
// ----------------------------------------------------------------------------
// WebSocket deframer checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "websocket_frame_deframer_defines.svh"

module wsd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [2:0]  kind_i,
  input wire logic [3:0]  error_i,
  input wire logic [15:0] status_i,
  input wire logic        last_i
);
  import wsd_pkg::*;

  `WSD_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
    out_valid_i && $stable(kind_i) && $stable(error_i))
  `WSD_ASSERT_IMPL(a_err_last, clk_i, rst_ni, out_valid_i && kind_i == KIND_ERROR,
    last_i && error_i != ERR_NONE)
  `WSD_ASSERT_IMPL(a_err_only, clk_i, rst_ni, out_valid_i && kind_i != KIND_ERROR,
    error_i == ERR_NONE)
  `WSD_ASSERT_IMPL(a_status, clk_i, rst_ni,
    out_valid_i && kind_i != KIND_ERROR && kind_i != KIND_CLOSE, status_i == 16'd0)

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_chan.valid),
  .out_ready_i (out_chan.ready),
  .kind_i      (out_chan.kind),
  .error_i     (out_chan.error),
  .status_i    (out_chan.status_code),
  .last_i      (out_chan.last)
);

`default_nettype wire
